/* sv/cpbd_pkg.sv */
// shared types, constants and codes for the cascaded pi buck duty block
`timescale 1ns / 1ps

package cpbd_pkg;

  // field widths
  localparam int VTGT_W  = 15;
  localparam int PGAIN_W = 16;
  localparam int IGAIN_W = 24;
  localparam int DUTY_W  = 11;
  localparam int CREF_W  = 13;
  localparam int SAMP_W  = 16;
  localparam int VINT_W  = 27;
  localparam int CINT_W  = 24;
  localparam int VERR_W  = 18;
  localparam int IERR_W  = 17;
  localparam int OPA_W   = IGAIN_W + 1;
  localparam int PROD_W  = OPA_W + VERR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // saturation limits
  localparam int VINT_LIMIT = 41943040;
  localparam int IREF_LIMIT = 67108864;
  localparam int CINT_LIMIT = 6710886;
  localparam int CREF_MAX   = 4096;
  localparam int DUTY_FULL  = 1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOUT_TARGET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_INTEG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_PROP_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_INTEG_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING    = 3'd6;

  // multiplier operand selects
  localparam logic [1:0] MUL_VOLT_INTEG = 2'd0;
  localparam logic [1:0] MUL_VOLT_PROP  = 2'd1;
  localparam logic [1:0] MUL_CURR_INTEG = 2'd2;
  localparam logic [1:0] MUL_CURR_PROP  = 2'd3;

  typedef struct packed {
    logic [VTGT_W-1:0]  vout_target;
    logic [PGAIN_W-1:0] volt_prop_gain;
    logic [IGAIN_W-1:0] volt_integ_gain;
    logic [PGAIN_W-1:0] curr_prop_gain;
    logic [IGAIN_W-1:0] curr_integ_gain;
    logic [DUTY_W-1:0]  duty_floor;
    logic [DUTY_W-1:0]  duty_ceiling;
  } cfg_t;

  typedef struct packed {
    logic       ld_in;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       vint_upd;
    logic       cref_ld;
    logic       ierr_ld;
    logic       cint_upd;
    logic       out_ld;
  } dp_cmd_t;

endpackage

/* sv/cpbd_cfg.sv */
// configuration register file of the cascaded pi buck duty block
`timescale 1ns / 1ps

module cpbd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [cpbd_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [cpbd_pkg::CFG_DATA_W-1:0]  wr_data,
  output cpbd_pkg::cfg_t                   cfg
);

  cpbd_pkg::cfg_t cfg_r;
  cpbd_pkg::cfg_t cfg_nxt;

  // register decode, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        cpbd_pkg::REG_VOUT_TARGET:
          cfg_nxt.vout_target = wr_data[cpbd_pkg::VTGT_W-1:0];
        cpbd_pkg::REG_VOLT_PROP_GAIN:
          cfg_nxt.volt_prop_gain = wr_data[cpbd_pkg::PGAIN_W-1:0];
        cpbd_pkg::REG_VOLT_INTEG_GAIN:
          cfg_nxt.volt_integ_gain = wr_data[cpbd_pkg::IGAIN_W-1:0];
        cpbd_pkg::REG_CURR_PROP_GAIN:
          cfg_nxt.curr_prop_gain = wr_data[cpbd_pkg::PGAIN_W-1:0];
        cpbd_pkg::REG_CURR_INTEG_GAIN:
          cfg_nxt.curr_integ_gain = wr_data[cpbd_pkg::IGAIN_W-1:0];
        cpbd_pkg::REG_DUTY_FLOOR:
          cfg_nxt.duty_floor = wr_data[cpbd_pkg::DUTY_W-1:0];
        cpbd_pkg::REG_DUTY_CEILING:
          cfg_nxt.duty_ceiling = wr_data[cpbd_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // all registers clear at reset except the ceiling, which starts at full duty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{vout_target:     '0,
                 volt_prop_gain:  '0,
                 volt_integ_gain: '0,
                 curr_prop_gain:  '0,
                 curr_integ_gain: '0,
                 duty_floor:      '0,
                 duty_ceiling:    cpbd_pkg::DUTY_W'(cpbd_pkg::DUTY_FULL)};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/cpbd_dp.sv */
// datapath: shared multiplier, integrators, saturation and duty clamp
`timescale 1ns / 1ps

module cpbd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cpbd_pkg::cfg_t                      cfg,
  input  cpbd_pkg::dp_cmd_t                   cmd,
  input  logic signed [cpbd_pkg::SAMP_W-1:0]  vout_sample,
  input  logic signed [cpbd_pkg::SAMP_W-1:0]  il_sample,
  output logic [cpbd_pkg::DUTY_W-1:0]         duty_out,
  output logic [cpbd_pkg::CREF_W-1:0]         current_ref
);

  localparam int VSUM_W = cpbd_pkg::PROD_W - 10 + 1;
  localparam int WIDE_W = cpbd_pkg::PROD_W + 3;
  localparam int DVAL_W = 32;

  logic signed [cpbd_pkg::VERR_W-1:0] verr_r, verr_nxt;
  logic signed [cpbd_pkg::SAMP_W-1:0] imeas_r;
  logic signed [cpbd_pkg::IERR_W-1:0] ierr_r, ierr_nxt;
  logic signed [cpbd_pkg::PROD_W-1:0] prod_r;
  logic signed [cpbd_pkg::VINT_W-1:0] vint_r, vint_nxt;
  logic signed [cpbd_pkg::CINT_W-1:0] cint_r, cint_nxt;
  logic [cpbd_pkg::CREF_W-1:0]        cref_r, cref_nxt;
  logic [cpbd_pkg::DUTY_W-1:0]        duty_r, duty_nxt;

  logic [cpbd_pkg::IGAIN_W-1:0]       gain_sel;
  logic signed [cpbd_pkg::OPA_W-1:0]  op_a;
  logic signed [cpbd_pkg::VERR_W-1:0] op_b;
  logic signed [VSUM_W-1:0]           vint_sum, cint_sum;
  logic signed [WIDE_W-1:0]           iref_sum, duty_sum;
  logic signed [DVAL_W-1:0]           duty_val;
  logic [cpbd_pkg::DUTY_W-1:0]        lo_lim, hi_lim;

  // voltage error taken at the input transfer
  assign verr_nxt = $signed({3'b000, cfg.vout_target}) - cpbd_pkg::VERR_W'(vout_sample);

  // multiplier operand selection
  always_comb begin
    unique case (cmd.mul_sel)
      cpbd_pkg::MUL_VOLT_INTEG: gain_sel = cfg.volt_integ_gain;
      cpbd_pkg::MUL_VOLT_PROP:  gain_sel = cpbd_pkg::IGAIN_W'(cfg.volt_prop_gain);
      cpbd_pkg::MUL_CURR_INTEG: gain_sel = cfg.curr_integ_gain;
      cpbd_pkg::MUL_CURR_PROP:  gain_sel = cpbd_pkg::IGAIN_W'(cfg.curr_prop_gain);
      default:                  gain_sel = '0;
    endcase
    op_a = $signed({1'b0, gain_sel});
    if (cmd.mul_sel == cpbd_pkg::MUL_VOLT_INTEG || cmd.mul_sel == cpbd_pkg::MUL_VOLT_PROP) begin
      op_b = verr_r;
    end else begin
      op_b = cpbd_pkg::VERR_W'(ierr_r);
    end
  end

  // outer integrator with saturation
  always_comb begin
    vint_sum = VSUM_W'(vint_r) + VSUM_W'(prod_r >>> 10);
    if (vint_sum > VSUM_W'(cpbd_pkg::VINT_LIMIT)) begin
      vint_nxt = cpbd_pkg::VINT_W'(cpbd_pkg::VINT_LIMIT);
    end else if (vint_sum < -VSUM_W'(cpbd_pkg::VINT_LIMIT)) begin
      vint_nxt = -cpbd_pkg::VINT_W'(cpbd_pkg::VINT_LIMIT);
    end else begin
      vint_nxt = cpbd_pkg::VINT_W'(vint_sum);
    end
  end

  // current reference, saturated to 0..4 A then cut to 2^-10 A
  always_comb begin
    iref_sum = (WIDE_W'(prod_r) <<< 2) + WIDE_W'(vint_r);
    if (iref_sum < 0) begin
      cref_nxt = '0;
    end else if (iref_sum > WIDE_W'(cpbd_pkg::IREF_LIMIT)) begin
      cref_nxt = cpbd_pkg::CREF_W'(cpbd_pkg::CREF_MAX);
    end else begin
      cref_nxt = iref_sum[26:14];
    end
  end

  assign ierr_nxt = $signed({4'b0000, cref_r}) - cpbd_pkg::IERR_W'(imeas_r);

  // inner integrator with saturation
  always_comb begin
    cint_sum = VSUM_W'(cint_r) + VSUM_W'(prod_r >>> 10);
    if (cint_sum > VSUM_W'(cpbd_pkg::CINT_LIMIT)) begin
      cint_nxt = cpbd_pkg::CINT_W'(cpbd_pkg::CINT_LIMIT);
    end else if (cint_sum < -VSUM_W'(cpbd_pkg::CINT_LIMIT)) begin
      cint_nxt = -cpbd_pkg::CINT_W'(cpbd_pkg::CINT_LIMIT);
    end else begin
      cint_nxt = cpbd_pkg::CINT_W'(cint_sum);
    end
  end

  // duty and clamp, floor checked first
  always_comb begin
    duty_sum = (WIDE_W'(prod_r) <<< 2) + WIDE_W'(cint_r);
    duty_val = DVAL_W'(duty_sum >>> 14);
    lo_lim   = (cfg.duty_floor > cpbd_pkg::DUTY_W'(cpbd_pkg::DUTY_FULL)) ?
               cpbd_pkg::DUTY_W'(cpbd_pkg::DUTY_FULL) : cfg.duty_floor;
    hi_lim   = (cfg.duty_ceiling > cpbd_pkg::DUTY_W'(cpbd_pkg::DUTY_FULL)) ?
               cpbd_pkg::DUTY_W'(cpbd_pkg::DUTY_FULL) : cfg.duty_ceiling;
    priority if (duty_val < $signed({21'd0, lo_lim})) begin
      duty_nxt = lo_lim;
    end else if (duty_val > $signed({21'd0, hi_lim})) begin
      duty_nxt = hi_lim;
    end else begin
      duty_nxt = duty_val[cpbd_pkg::DUTY_W-1:0];
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vint_r <= '0;
      cint_r <= '0;
    end else begin
      if (cmd.vint_upd) vint_r <= vint_nxt;
      if (cmd.cint_upd) cint_r <= cint_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      verr_r  <= verr_nxt;
      imeas_r <= il_sample;
    end
    if (cmd.mul_en)  prod_r <= op_a * op_b;
    if (cmd.cref_ld) cref_r <= cref_nxt;
    if (cmd.ierr_ld) ierr_r <= ierr_nxt;
    if (cmd.out_ld)  duty_r <= duty_nxt;
  end

  // the reference leaves with the duty it produced
  logic [cpbd_pkg::CREF_W-1:0] cref_out_r;
  always_ff @(posedge clk) begin
    if (cmd.out_ld) cref_out_r <= cref_r;
  end

  assign duty_out    = duty_r;
  assign current_ref = cref_out_r;

  a_vint_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vint_r <= cpbd_pkg::VINT_W'(cpbd_pkg::VINT_LIMIT)) &&
    (vint_r >= -cpbd_pkg::VINT_W'(cpbd_pkg::VINT_LIMIT)))
    else $error("outer integrator out of range");

  a_cint_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cint_r <= cpbd_pkg::CINT_W'(cpbd_pkg::CINT_LIMIT)) &&
    (cint_r >= -cpbd_pkg::CINT_W'(cpbd_pkg::CINT_LIMIT)))
    else $error("inner integrator out of range");

  a_cref_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cref_ld |=> (cref_r <= cpbd_pkg::CREF_W'(cpbd_pkg::CREF_MAX)))
    else $error("current reference above 4 A");

endmodule

/* sv/cpbd_ctrl.sv */
// controller: sequences one sample through the shared datapath and owns the handshakes
`timescale 1ns / 1ps

module cpbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cpbd_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MV1  = 3'd1;
  localparam logic [2:0] ST_MV2  = 3'd2;
  localparam logic [2:0] ST_MV3  = 3'd3;
  localparam logic [2:0] ST_MI0  = 3'd4;
  localparam logic [2:0] ST_MI1  = 3'd5;
  localparam logic [2:0] ST_MI2  = 3'd6;
  localparam logic [2:0] ST_MI3  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // sequencing and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.ld_in = in_valid;
        if (in_valid) state_nxt = ST_MV1;
      end
      ST_MV1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpbd_pkg::MUL_VOLT_INTEG;
        state_nxt   = ST_MV2;
      end
      ST_MV2: begin
        cmd.vint_upd = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = cpbd_pkg::MUL_VOLT_PROP;
        state_nxt    = ST_MV3;
      end
      ST_MV3: begin
        cmd.cref_ld = 1'b1;
        state_nxt   = ST_MI0;
      end
      ST_MI0: begin
        cmd.ierr_ld = 1'b1;
        state_nxt   = ST_MI1;
      end
      ST_MI1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpbd_pkg::MUL_CURR_INTEG;
        state_nxt   = ST_MI2;
      end
      ST_MI2: begin
        cmd.cint_upd = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = cpbd_pkg::MUL_CURR_PROP;
        state_nxt    = ST_MI3;
      end
      ST_MI3: begin
        // wait here while the previous result is still held
        if (slot_free) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MV1))
    else $error("transfer did not start the sequence");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MI3 && out_valid_r && !out_ready) |=> (state_r == ST_MI3))
    else $error("result written over a pending transfer");

endmodule

/* sv/cascaded_pi_buck_duty.sv */
// top level of the cascaded pi voltage and current loop for a buck converter
`timescale 1ns / 1ps

// Each sample pair runs from input transfer to result one sample at a time:
// one shared 25x18 multiplier is used four times (outer integral, outer
// proportional, inner integral, inner proportional) with the integrator
// updates and the reference step in between. The next sample is taken in
// the cycle after the result is registered, so the block cannot take a new
// sample before it is through with the last one; a held result stalls the
// block only when the following one is ready to leave. cfg_ready is always
// high; write registers only while no sample is in flight.
module cascaded_pi_buck_duty (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cpbd_pkg::SAMP_W-1:0]  in_vout_sample,
  input  logic signed [cpbd_pkg::SAMP_W-1:0]  in_il_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cpbd_pkg::DUTY_W-1:0]         out_duty_out,
  output logic [cpbd_pkg::CREF_W-1:0]         out_current_ref,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cpbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cpbd_pkg::cfg_t    cfg;
  cpbd_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  cpbd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // sequencer
  cpbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic
  cpbd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .vout_sample (in_vout_sample),
    .il_sample   (in_il_sample),
    .duty_out    (out_duty_out),
    .current_ref (out_current_ref)
  );

endmodule

/* bench/tb_cascaded_pi_buck_duty.sv */
// self-checking bench for the cascaded pi buck duty block, with its own loop predictor
`timescale 1ns / 1ps

module tb_cascaded_pi_buck_duty;

  localparam int CLK_HALF    = 5;
  localparam int LATENCY     = 8;
  localparam int HOLD_CYCLES = 120;
  localparam int MAX_REPORTS = 100;
  localparam int LIMIT_NS    = 5_000_000;

  // no register lives at this index, writes to it must be dropped
  localparam logic [cpbd_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [cpbd_pkg::DUTY_W-1:0] duty;
    logic [cpbd_pkg::CREF_W-1:0] cref;
  } duty_result_t;

  // loop predictor and result checker
  class duty_loop_checker;
    cpbd_pkg::cfg_t regs;
    longint         volt_acc;
    longint         curr_acc;
    longint         last_cref;
    duty_result_t   pending_duty[$];
    int             errors;
    int             results_seen;

    function void clear();
      regs              = '0;
      regs.duty_ceiling = cpbd_pkg::DUTY_W'(cpbd_pkg::DUTY_FULL);
      volt_acc          = 0;
      curr_acc          = 0;
      last_cref         = 0;
      errors            = 0;
      results_seen      = 0;
      pending_duty.delete();
    endfunction

    function int pending();
      return pending_duty.size();
    endfunction

    function longint limit(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // register write, masked to the register width
    function void set_reg(logic [cpbd_pkg::CFG_IDX_W-1:0]  idx,
                          logic [cpbd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        cpbd_pkg::REG_VOUT_TARGET:
          regs.vout_target     = data[cpbd_pkg::VTGT_W-1:0];
        cpbd_pkg::REG_VOLT_PROP_GAIN:
          regs.volt_prop_gain  = data[cpbd_pkg::PGAIN_W-1:0];
        cpbd_pkg::REG_VOLT_INTEG_GAIN:
          regs.volt_integ_gain = data[cpbd_pkg::IGAIN_W-1:0];
        cpbd_pkg::REG_CURR_PROP_GAIN:
          regs.curr_prop_gain  = data[cpbd_pkg::PGAIN_W-1:0];
        cpbd_pkg::REG_CURR_INTEG_GAIN:
          regs.curr_integ_gain = data[cpbd_pkg::IGAIN_W-1:0];
        cpbd_pkg::REG_DUTY_FLOOR:
          regs.duty_floor      = data[cpbd_pkg::DUTY_W-1:0];
        cpbd_pkg::REG_DUTY_CEILING:
          regs.duty_ceiling    = data[cpbd_pkg::DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted sample pair: run both loops and queue the result
    function void note_sample(logic signed [cpbd_pkg::SAMP_W-1:0] vs,
                              logic signed [cpbd_pkg::SAMP_W-1:0] il);
      longint       verr;
      longint       iref;
      longint       ierr;
      longint       duty;
      longint       lo;
      longint       hi;
      duty_result_t r;
      // outer voltage loop
      verr     = longint'(regs.vout_target) - longint'(vs);
      volt_acc = limit(volt_acc + ((longint'(regs.volt_integ_gain) * verr) >>> 10),
                       -cpbd_pkg::VINT_LIMIT, cpbd_pkg::VINT_LIMIT);
      iref     = limit(4 * longint'(regs.volt_prop_gain) * verr + volt_acc,
                       0, cpbd_pkg::IREF_LIMIT);
      // reference is quantised before the inner loop sees it
      last_cref = iref >>> 14;
      // inner current loop
      ierr     = last_cref - longint'(il);
      curr_acc = limit(curr_acc + ((longint'(regs.curr_integ_gain) * ierr) >>> 10),
                       -cpbd_pkg::CINT_LIMIT, cpbd_pkg::CINT_LIMIT);
      duty     = (4 * longint'(regs.curr_prop_gain) * ierr + curr_acc) >>> 14;
      // bounds above full duty read as full, floor wins over ceiling
      lo = (regs.duty_floor > cpbd_pkg::DUTY_FULL) ?
           cpbd_pkg::DUTY_FULL : longint'(regs.duty_floor);
      hi = (regs.duty_ceiling > cpbd_pkg::DUTY_FULL) ?
           cpbd_pkg::DUTY_FULL : longint'(regs.duty_ceiling);
      if (duty < lo) begin
        duty = lo;
      end else if (duty > hi) begin
        duty = hi;
      end
      r.duty = cpbd_pkg::DUTY_W'(duty);
      r.cref = cpbd_pkg::CREF_W'(last_cref);
      pending_duty.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_duty(logic [cpbd_pkg::DUTY_W-1:0] duty, logic [cpbd_pkg::CREF_W-1:0] cref);
      duty_result_t want;
      results_seen++;
      if (pending_duty.size() == 0) begin
        report($sformatf("result %0d (duty %0d, cref %0d) with no sample pending",
                         results_seen, duty, cref));
        return;
      end
      want = pending_duty.pop_front();
      if (duty !== want.duty)
        report($sformatf("result %0d duty_out %0d, predicted %0d",
                         results_seen, duty, want.duty));
      if (cref !== want.cref)
        report($sformatf("result %0d current_ref %0d, predicted %0d",
                         results_seen, cref, want.cref));
    endtask
  endclass

  logic                                  clk             = 1'b0;
  logic                                  rst_n           = 1'b0;
  logic                                  in_valid        = 1'b0;
  logic                                  in_ready;
  logic signed [cpbd_pkg::SAMP_W-1:0]    in_vout_sample  = '0;
  logic signed [cpbd_pkg::SAMP_W-1:0]    in_il_sample    = '0;
  logic                                  out_valid;
  logic                                  out_ready       = 1'b0;
  logic [cpbd_pkg::DUTY_W-1:0]           out_duty_out;
  logic [cpbd_pkg::CREF_W-1:0]           out_current_ref;
  logic                                  cfg_valid       = 1'b0;
  logic                                  cfg_ready;
  logic [cpbd_pkg::CFG_IDX_W-1:0]        cfg_index       = '0;
  logic [cpbd_pkg::CFG_DATA_W-1:0]       cfg_data        = '0;

  duty_loop_checker chk;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int idle_mode[4]  = '{0, 52, 0, 22};
  int stall_mode[4] = '{0, 0, 52, 22};

  cascaded_pi_buck_duty dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_vout_sample  (in_vout_sample),
    .in_il_sample    (in_il_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_duty_out    (out_duty_out),
    .out_current_ref (out_current_ref),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // clock
  always #(CLK_HALF) clk = ~clk;

  // transfer monitor on all three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) chk.set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) chk.note_sample(in_vout_sample, in_il_sample);
      if (out_valid && out_ready) chk.check_duty(out_duty_out, out_current_ref);
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int held_left;
    int holds_taken;
    held_left   = 0;
    holds_taken = 0;
    forever begin
      @(negedge clk);
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        held_left   = HOLD_CYCLES;
      end
      if (held_left > 0) begin
        out_ready <= 1'b0;
        held_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("tb_cascaded_pi_buck_duty: done, errors");
    $finish;
  end

  task automatic write_cfg(logic [cpbd_pkg::CFG_IDX_W-1:0]  idx,
                           logic [cpbd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one sample pair, with random idle cycles ahead of it
  task automatic send_sample(logic signed [cpbd_pkg::SAMP_W-1:0] vs,
                             logic signed [cpbd_pkg::SAMP_W-1:0] il);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_vout_sample <= vs;
    in_il_sample   <= il;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid after the last transfer, then let the block go quiet
  task automatic close_and_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [cpbd_pkg::CFG_DATA_W-1:0] pick_prop();
    case ($urandom_range(3))
      0:       return '0;
      1:       return cpbd_pkg::CFG_DATA_W'($urandom_range(0, 16'h1fff));
      2:       return cpbd_pkg::CFG_DATA_W'($urandom_range(0, 16'hffff));
      default: return cpbd_pkg::CFG_DATA_W'(16'hffff);
    endcase
  endfunction

  function automatic logic [cpbd_pkg::CFG_DATA_W-1:0] pick_integ();
    case ($urandom_range(3))
      0:       return '0;
      1:       return cpbd_pkg::CFG_DATA_W'($urandom_range(0, 1 << 16));
      2:       return cpbd_pkg::CFG_DATA_W'($urandom_range(0, 24'hffffff));
      default: return cpbd_pkg::CFG_DATA_W'(24'hffffff);
    endcase
  endfunction

  // fresh settings for a random phase, all registers touched
  task automatic apply_random_config();
    write_cfg(cpbd_pkg::REG_VOUT_TARGET, cpbd_pkg::CFG_DATA_W'($urandom));
    write_cfg(cpbd_pkg::REG_VOLT_PROP_GAIN, pick_prop());
    write_cfg(cpbd_pkg::REG_VOLT_INTEG_GAIN, pick_integ());
    write_cfg(cpbd_pkg::REG_CURR_PROP_GAIN, pick_prop());
    write_cfg(cpbd_pkg::REG_CURR_INTEG_GAIN, pick_integ());
    if ($urandom_range(3) == 0)
      write_cfg(cpbd_pkg::REG_DUTY_FLOOR,
                cpbd_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
    else
      write_cfg(cpbd_pkg::REG_DUTY_FLOOR,
                cpbd_pkg::CFG_DATA_W'($urandom_range(0, 200)));
    if ($urandom_range(3) == 0)
      write_cfg(cpbd_pkg::REG_DUTY_CEILING,
                cpbd_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
    else
      write_cfg(cpbd_pkg::REG_DUTY_CEILING,
                cpbd_pkg::CFG_DATA_W'($urandom_range(800, 1024)));
    if ($urandom_range(3) == 0) write_cfg(REG_NONE, cpbd_pkg::CFG_DATA_W'($urandom));
  endtask

  // mostly samples close to the operating point so the integrators move,
  // the rest fully random
  task automatic random_samples(int n);
    int                                 r;
    int                                 vo;
    int                                 io;
    logic signed [cpbd_pkg::SAMP_W-1:0] vs;
    logic signed [cpbd_pkg::SAMP_W-1:0] il;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(2))
          0:       r = 16;
          1:       r = 256;
          default: r = 4096;
        endcase
        vo = int'(chk.regs.vout_target) + int'($urandom_range(2 * r)) - r;
        if (vo > 32767) vo = 32767;
        io = int'(chk.last_cref) + int'($urandom_range(2 * r)) - r;
        vs = cpbd_pkg::SAMP_W'(vo);
        il = cpbd_pkg::SAMP_W'(io);
      end else begin
        vs = cpbd_pkg::SAMP_W'($urandom);
        il = cpbd_pkg::SAMP_W'($urandom);
      end
      send_sample(vs, il);
    end
  endtask

  // stimulus
  initial begin : stimulus
    chk = new;
    chk.clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: all gains zero, duty held at the floor
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    close_and_drain();

    // moderate gains, index beyond the register list must be dropped
    write_cfg(cpbd_pkg::REG_VOUT_TARGET, cpbd_pkg::CFG_DATA_W'(12288));
    write_cfg(cpbd_pkg::REG_VOLT_PROP_GAIN, cpbd_pkg::CFG_DATA_W'(16'h0800));
    write_cfg(cpbd_pkg::REG_VOLT_INTEG_GAIN, cpbd_pkg::CFG_DATA_W'(24'h004000));
    write_cfg(cpbd_pkg::REG_CURR_PROP_GAIN, cpbd_pkg::CFG_DATA_W'(16'h2000));
    write_cfg(cpbd_pkg::REG_CURR_INTEG_GAIN, cpbd_pkg::CFG_DATA_W'(24'h010000));
    write_cfg(cpbd_pkg::REG_DUTY_FLOOR, cpbd_pkg::CFG_DATA_W'(40));
    write_cfg(cpbd_pkg::REG_DUTY_CEILING, cpbd_pkg::CFG_DATA_W'(980));
    write_cfg(REG_NONE, cpbd_pkg::CFG_DATA_W'(24'hffffff));
    send_sample(16'sd12288, 16'sd0);
    send_sample(16'sd12000, 16'sd1000);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sd12288, 16'sd4096);
    send_sample(16'sd0, 16'sd2048);
    close_and_drain();

    // every register at its top, duty bounds above full duty
    write_cfg(cpbd_pkg::REG_VOUT_TARGET, cpbd_pkg::CFG_DATA_W'(15'h7fff));
    write_cfg(cpbd_pkg::REG_VOLT_PROP_GAIN, cpbd_pkg::CFG_DATA_W'(16'hffff));
    write_cfg(cpbd_pkg::REG_VOLT_INTEG_GAIN, cpbd_pkg::CFG_DATA_W'(24'hffffff));
    write_cfg(cpbd_pkg::REG_CURR_PROP_GAIN, cpbd_pkg::CFG_DATA_W'(16'hffff));
    write_cfg(cpbd_pkg::REG_CURR_INTEG_GAIN, cpbd_pkg::CFG_DATA_W'(24'hffffff));
    write_cfg(cpbd_pkg::REG_DUTY_FLOOR, cpbd_pkg::CFG_DATA_W'(2047));
    write_cfg(cpbd_pkg::REG_DUTY_CEILING, cpbd_pkg::CFG_DATA_W'(2047));
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sd0, 16'sd0);
    close_and_drain();

    // floor above ceiling: low duty gives the floor, high duty the ceiling
    write_cfg(cpbd_pkg::REG_VOUT_TARGET, cpbd_pkg::CFG_DATA_W'(8192));
    write_cfg(cpbd_pkg::REG_VOLT_PROP_GAIN, cpbd_pkg::CFG_DATA_W'(16'h1000));
    write_cfg(cpbd_pkg::REG_VOLT_INTEG_GAIN, '0);
    write_cfg(cpbd_pkg::REG_CURR_PROP_GAIN, cpbd_pkg::CFG_DATA_W'(16'h1000));
    write_cfg(cpbd_pkg::REG_CURR_INTEG_GAIN, '0);
    write_cfg(cpbd_pkg::REG_DUTY_FLOOR, cpbd_pkg::CFG_DATA_W'(900));
    write_cfg(cpbd_pkg::REG_DUTY_CEILING, cpbd_pkg::CFG_DATA_W'(100));
    send_sample(16'sd8192, 16'sh7fff);
    send_sample(16'sd8192, -16'sh8000);
    send_sample(16'sd8200, 16'sd2500);
    close_and_drain();

    // ceiling just above full duty
    write_cfg(cpbd_pkg::REG_DUTY_FLOOR, '0);
    write_cfg(cpbd_pkg::REG_DUTY_CEILING, cpbd_pkg::CFG_DATA_W'(1025));
    send_sample(16'sd8192, -16'sh8000);
    send_sample(16'sd8192, 16'sh7fff);
    close_and_drain();

    // random phases, cycling through the idle and stall patterns
    for (int p = 0; p < 8; p++) begin
      apply_random_config();
      idle_pct  = idle_mode[p % 4];
      stall_pct = stall_mode[p % 4];
      // long hold-off on the result side while samples keep coming
      if (p == 4) hold_requests++;
      random_samples(69);
      close_and_drain();
    end

    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("tb_cascaded_pi_buck_duty: done, clean");
    end else begin
      $display("tb_cascaded_pi_buck_duty: done, errors");
    end
    $finish;
  end

endmodule
